### hw/rtl/mctd_pkg.sv
// Shared types and constants of the multi-channel timestamp debouncer.
package mctd_pkg;

   localparam int unsigned CHANNEL_W  = 5;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned DEBOUNCE_W = 16;
   localparam int unsigned MASK_W     = 32;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes, taken from csr_paddr[2]
   localparam logic REG_DEBOUNCE_MS = 1'b0;
   localparam logic REG_ENABLE_MASK = 1'b1;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [MASK_W-1:0]     MASK_RESET     = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0]    COUNT_MAX      = 6'h3F;
   localparam logic [TIME_W-1:0]     TIME_IDLE      = 32'h0000_0000;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 pin_level;
      logic [TIME_W-1:0]    now_ms;
   } req_type;

   typedef struct packed {
      logic               stable_level;
      logic               level_validated_change;
      logic               change_reported;
      logic [COUNT_W-1:0] changed_channel_count;
   } rsp_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [MASK_W-1:0]     input_enable_mask;
   } cfg_type;

endpackage

### hw/rtl/mctd_chan_core.sv
// Per-channel debounce state and the combinational read and registered update of one sample.
module mctd_chan_core #(
   parameter int unsigned NUM_CHANNELS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  mctd_pkg::req_type req,
   input  mctd_pkg::cfg_type cfg,
   output mctd_pkg::rsp_type rsp
);

   localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic                        last_sample_ff     [NUM_CHANNELS];
   logic [mctd_pkg::TIME_W-1:0] change_time_ff     [NUM_CHANNELS];
   logic                        validated_level_ff [NUM_CHANNELS];
   logic                        change_flag_ff     [NUM_CHANNELS];
   logic [mctd_pkg::COUNT_W-1:0] flag_count_ff;
   logic [mctd_pkg::COUNT_W-1:0] flag_count_in;

   logic [6:0]                  ch_ext;
   logic [IDX_W-1:0]            idx;
   logic                        in_range;
   logic                        enabled;
   logic                        last_level;
   logic [mctd_pkg::TIME_W-1:0] ct;
   logic                        val_level;
   logic                        flag;
   logic [mctd_pkg::TIME_W-1:0] elapsed;
   logic                        differ;
   logic                        settle;
   logic                        accept;
   logic                        report;

   always_comb begin
      ch_ext     = 7'(req.channel);
      idx        = ch_ext[IDX_W-1:0];
      in_range   = (32'(req.channel) < NUM_CHANNELS);
      // The channel field is five bits wide, so every reachable channel has a mask bit.
      enabled    = in_range && cfg.input_enable_mask[req.channel];
      last_level = last_sample_ff[idx];
      ct         = change_time_ff[idx];
      val_level  = validated_level_ff[idx];
      flag       = change_flag_ff[idx];
      elapsed    = req.now_ms - ct;
      differ     = req.pin_level != last_level;
      settle     = enabled && !differ && (ct != mctd_pkg::TIME_IDLE) &&
                   (elapsed > 32'(cfg.debounce_ms));
      accept     = settle && (val_level != req.pin_level);
      report     = accept && !flag;
      flag_count_in = flag_count_ff;
      if (report && (flag_count_ff != mctd_pkg::COUNT_MAX)) begin
         flag_count_in = flag_count_ff + 6'd1;
      end
      rsp.stable_level           = in_range && (accept ? req.pin_level : val_level);
      rsp.level_validated_change = accept;
      rsp.change_reported        = report;
      rsp.changed_channel_count  = flag_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_sample_ff[i]     <= 1'b0;
            change_time_ff[i]     <= mctd_pkg::TIME_IDLE;
            validated_level_ff[i] <= 1'b0;
            change_flag_ff[i]     <= 1'b0;
         end
         flag_count_ff <= '0;
      end else if (step_en) begin
         if (enabled && differ) begin
            change_time_ff[idx] <= req.now_ms;
            last_sample_ff[idx] <= req.pin_level;
         end
         if (settle) begin
            change_time_ff[idx] <= mctd_pkg::TIME_IDLE;
         end
         if (accept) begin
            validated_level_ff[idx] <= req.pin_level;
         end
         if (report) begin
            change_flag_ff[idx] <= 1'b1;
         end
         flag_count_ff <= flag_count_in;
      end
   end

endmodule

### hw/rtl/multi_channel_timestamp_debouncer.sv
// Top level of the multi-channel timestamp debouncer: handshakes, registers and pipeline.
//
//   Channel   Direction  Ports                          Moves
//   req       in         req_valid req_stall req_data   one pin sample per request
//   rsp       out        rsp_valid rsp_stall rsp_data   one result per request
//   csr       in/out     csr_psel .. csr_pready         debounce time, enable mask
//
// A request is registered at acceptance and evaluated once the output register can take
// it, when the per-channel state is read, updated and the result registered.
// One request per cycle is sustained while no result is stalled; the state update is a read-modify-write.
// Reset clears all channel state, flags and the count and restores the register defaults.
// A stalled result holds the input register, which then stalls the request side.
module multi_channel_timestamp_debouncer #(
   parameter int unsigned NUM_CHANNELS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mctd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mctd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mctd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mctd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mctd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   mctd_pkg::cfg_type cfg_ff;
   mctd_pkg::req_type in_ff;
   logic              in_valid_ff;
   mctd_pkg::rsp_type out_ff;
   logic              out_valid_ff;
   mctd_pkg::rsp_type core_rsp;
   logic              advance;
   logic              step_en;
   logic              in_load;
   logic              csr_write;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && advance;
   assign req_stall = reset || (in_valid_ff && !advance);
   assign in_load   = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         mctd_pkg::REG_DEBOUNCE_MS: csr_prdata = 32'(cfg_ff.debounce_ms);
         mctd_pkg::REG_ENABLE_MASK: csr_prdata = cfg_ff.input_enable_mask;
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms       <= mctd_pkg::DEBOUNCE_RESET;
         cfg_ff.input_enable_mask <= mctd_pkg::MASK_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            mctd_pkg::REG_DEBOUNCE_MS: cfg_ff.debounce_ms <= csr_pwdata[15:0];
            mctd_pkg::REG_ENABLE_MASK: cfg_ff.input_enable_mask <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= 1'b1;
         end else if (step_en) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_ff <= req_data;
      end
      if (step_en) begin
         out_ff <= core_rsp;
      end
   end

   mctd_chan_core #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_ff),
      .cfg     (cfg_ff),
      .rsp     (core_rsp)
   );

endmodule

### hw/rtl/mctd_checker.sv
// Port-level checks of the debouncer, bound to its top level.
module mctd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mctd_pkg::rsp_type rsp_data
);

   // A result held back by the consumer stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A result only appears after a request was taken, once through each register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a preceding request");

   // A newly set flag is always part of a validated change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.change_reported |-> rsp_data.level_validated_change)
      else $error("flag reported without a validated change");

   // Once a flag has been reported the count cannot be zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.change_reported |-> rsp_data.changed_channel_count != '0)
      else $error("flag reported with a zero count");

endmodule

bind multi_channel_timestamp_debouncer mctd_checker u_mctd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/multi_channel_timestamp_debouncer_tb.sv
// Self-checking testbench for the multi-channel timestamp debouncer.
module multi_channel_timestamp_debouncer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH       = 32;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400_000;

   logic                                clock;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   mctd_pkg::req_type                   req_data    = '0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   mctd_pkg::rsp_type                   rsp_data;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [mctd_pkg::CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [mctd_pkg::CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [mctd_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   multi_channel_timestamp_debouncer #(.NUM_CHANNELS(NUM_CH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Debouncer state as the testbench sees it.
   logic                                last_level [NUM_CH];
   logic [mctd_pkg::TIME_W-1:0]         changed_at [NUM_CH];
   logic                                held_level [NUM_CH];
   logic                                flagged    [NUM_CH];
   logic [mctd_pkg::COUNT_W-1:0]        flagged_total;
   logic [mctd_pkg::DEBOUNCE_W-1:0]     debounce_now;
   logic [mctd_pkg::MASK_W-1:0]         enable_mask;

   mctd_pkg::rsp_type expected_results[$];
   int      error_count     = 0;
   int      requests_sent   = 0;
   int      validated_seen  = 0;
   int      flags_raised    = 0;
   int      send_gap_pct    = 0;
   int      hold_pct        = 0;
   int      cycle_count     = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_results.size());
         $display("multi_channel_timestamp_debouncer_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (hold_pct != 0) && ($urandom_range(99) < hold_pct);
   end

   // Computes the result of one sample and advances the debouncer state.
   function automatic mctd_pkg::rsp_type debounce_step(input mctd_pkg::req_type r);
      mctd_pkg::rsp_type           res;
      int                          ch;
      logic [mctd_pkg::TIME_W-1:0] elapsed;
      res = '0;
      ch = r.channel;
      if (enable_mask[ch]) begin
         elapsed = r.now_ms - changed_at[ch];
         if (r.pin_level != last_level[ch]) begin
            changed_at[ch] = r.now_ms;
            last_level[ch] = r.pin_level;
         end else if (changed_at[ch] != mctd_pkg::TIME_IDLE &&
                      elapsed > {16'h0000, debounce_now}) begin
            changed_at[ch] = mctd_pkg::TIME_IDLE;
            if (held_level[ch] != r.pin_level) begin
               held_level[ch] = r.pin_level;
               res.level_validated_change = 1'b1;
               if (!flagged[ch]) begin
                  flagged[ch] = 1'b1;
                  res.change_reported = 1'b1;
                  if (flagged_total != mctd_pkg::COUNT_MAX)
                     flagged_total++;
               end
            end
         end
      end
      res.stable_level = held_level[ch];
      res.changed_channel_count = flagged_total;
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      mctd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result with no request outstanding, actual %p", $time, rsp_data);
         end else begin
            want = expected_results.pop_front();
            check_field("stable_level", 8'(want.stable_level), 8'(rsp_data.stable_level));
            check_field("level_validated_change", 8'(want.level_validated_change),
                        8'(rsp_data.level_validated_change));
            check_field("change_reported", 8'(want.change_reported),
                        8'(rsp_data.change_reported));
            check_field("changed_channel_count", 8'(want.changed_channel_count),
                        8'(rsp_data.changed_channel_count));
         end
      end
   end

   task automatic send_sample(input mctd_pkg::req_type r);
      mctd_pkg::rsp_type res;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      res = debounce_step(r);
      expected_results.push_back(res);
      requests_sent++;
      if (res.level_validated_change)
         validated_seen++;
      if (res.change_reported)
         flags_raised++;
   endtask

   task automatic sample(input int ch, input logic lvl,
                         input logic [mctd_pkg::TIME_W-1:0] ms);
      mctd_pkg::req_type r;
      r.channel   = ch[mctd_pkg::CHANNEL_W-1:0];
      r.pin_level = lvl;
      r.now_ms    = ms;
      send_sample(r);
   endtask

   // Waits until every request has produced its result and the pipeline is empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic index,
                            input logic [mctd_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == mctd_pkg::REG_DEBOUNCE_MS)
         debounce_now = value[mctd_pkg::DEBOUNCE_W-1:0];
      else
         enable_mask = value;
   endtask

   task automatic test_directed();
      // Steady for exactly the debounce time is not enough; one more millisecond is.
      sample(0, 1'b1, 32'd100);
      sample(0, 1'b1, 32'd120);
      sample(0, 1'b1, 32'd121);
      sample(0, 1'b1, 32'd200);
      // Returning to low is validated, but the flag is already set.
      sample(0, 1'b0, 32'd300);
      sample(0, 1'b0, 32'd321);
      // A change sampled at time zero looks idle and is never validated.
      sample(31, 1'b1, 32'd0);
      sample(31, 1'b1, 32'd5000);
      // A bounce back to the validated level stops the timer without a change.
      sample(31, 1'b0, 32'd5001);
      sample(31, 1'b0, 32'd6000);
      // The elapsed time is taken across the wrap of the millisecond counter.
      sample(5, 1'b1, 32'hFFFF_FFF0);
      sample(5, 1'b1, 32'h0000_0010);
      sample(10, 1'b1, 32'hFFFF_FFFF);
      sample(10, 1'b1, 32'h0000_0013);
      sample(10, 1'b1, 32'h0000_0014);
      sample(17, 1'b1, 32'h8000_0000);
      sample(17, 1'b0, 32'h8000_0005);
      sample(17, 1'b0, 32'h8000_0100);
      sample(30, 1'b1, 32'h7FFF_FFFF);
      sample(30, 1'b1, 32'hFFFF_FFFF);
   endtask

   task automatic test_debounce_extremes();
      drain();
      csr_write(mctd_pkg::REG_DEBOUNCE_MS, 32'd0);
      sample(3, 1'b1, 32'd50);
      sample(3, 1'b1, 32'd50);
      sample(3, 1'b1, 32'd51);
      drain();
      csr_write(mctd_pkg::REG_DEBOUNCE_MS, 32'd65535);
      sample(4, 1'b1, 32'd1000);
      sample(4, 1'b1, 32'd66535);
      sample(4, 1'b1, 32'd66536);
      sample(4, 1'b0, 32'd70000);
      sample(4, 1'b0, 32'hFFFF_FFFF);
   endtask

   task automatic test_enable_mask();
      drain();
      csr_write(mctd_pkg::REG_DEBOUNCE_MS, 32'd20);
      csr_write(mctd_pkg::REG_ENABLE_MASK, 32'h0000_0000);
      for (int i = 0; i < 6; i++)
         sample(int'($urandom_range(31)), 1'($urandom_range(1)), $urandom);
      drain();
      csr_write(mctd_pkg::REG_ENABLE_MASK, 32'h5555_5555);
      // Channel 1 is masked off and keeps its state; channel 2 debounces.
      sample(1, 1'b1, 32'd1000);
      sample(1, 1'b1, 32'd2000);
      sample(2, 1'b1, 32'd1000);
      sample(2, 1'b1, 32'd2000);
      drain();
      csr_write(mctd_pkg::REG_ENABLE_MASK, 32'hFFFF_FFFF);
      sample(1, 1'b1, 32'd3000);
      sample(1, 1'b1, 32'd3100);
   endtask

   task automatic run_phase(input int items, input int gap_pct, input int stall_pct,
                            input logic [mctd_pkg::CSR_DATA_W-1:0] deb,
                            input logic [mctd_pkg::CSR_DATA_W-1:0] mask,
                            input logic [mctd_pkg::TIME_W-1:0] start_ms);
      mctd_pkg::req_type           r;
      logic [mctd_pkg::TIME_W-1:0] clock_ms;
      int                          pick;
      drain();
      csr_write(mctd_pkg::REG_DEBOUNCE_MS, deb);
      csr_write(mctd_pkg::REG_ENABLE_MASK, mask);
      send_gap_pct = gap_pct;
      hold_pct     = stall_pct;
      clock_ms     = start_ms;
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // Noise: any channel, any level, any time.
            r.channel   = 5'($urandom_range(31));
            r.pin_level = 1'($urandom_range(1));
            r.now_ms    = $urandom;
         end else begin
            // A mostly steady level on a few busy channels, with time moving on.
            r.channel   = (pick < 75) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
            r.pin_level = ($urandom_range(99) < 70) ? last_level[r.channel]
                                                    : ~last_level[r.channel];
            clock_ms   += 32'($urandom_range(32'((debounce_now >> 2) + 2)));
            r.now_ms    = clock_ms;
         end
         send_sample(r);
      end
   endtask

   task automatic test_random_traffic();
      run_phase(500, 0, 0, 32'd20, 32'hFFFF_FFFF, 32'd1);
      run_phase(500, 62, 0, 32'd0, $urandom, $urandom);
      run_phase(500, 0, 62, 32'd65535, 32'hFFFF_FFFF, 32'hFFFF_0000);
      run_phase(500, 22, 22, $urandom_range(1, 300), $urandom | 32'h0000_00FF, $urandom);
      hold_pct     = 0;
      send_gap_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < NUM_CH; i++) begin
         last_level[i] = 1'b0;
         changed_at[i] = mctd_pkg::TIME_IDLE;
         held_level[i] = 1'b0;
         flagged[i]    = 1'b0;
      end
      flagged_total = '0;
      debounce_now  = mctd_pkg::DEBOUNCE_RESET;
      enable_mask   = mctd_pkg::MASK_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_debounce_extremes();
      test_enable_mask();
      test_random_traffic();
      drain();

      $display("Sent %0d requests across four handshake phases and several register settings.",
               requests_sent);
      $display("Saw %0d validated level changes and %0d channel flags raised.",
               validated_seen, flags_raised);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("multi_channel_timestamp_debouncer_tb: clean");
      end else begin
         $display("multi_channel_timestamp_debouncer_tb: errors");
      end
      $finish;
   end

endmodule
